// ----- rtl/assert_macros.svh -----
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle, idle during reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle, idle during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/orav_pkg.sv -----
// shared constants, types and state codes of the outlier-rejecting average
package orav_pkg;

	localparam int WINDOW_DEPTH = 16;
	localparam int SAMPLE_W     = 10;
	localparam int SMOOTH_W     = 11;
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
	localparam int ADDR_W       = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W        = SAMPLE_W + CNT_W;
	localparam int DSTEP_W      = $clog2(SUM_W);
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int S_TDATA_W    = 16;
	localparam int M_TDATA_W    = 16;

	localparam logic signed [SMOOTH_W-1:0] SMOOTH_NONE = -11'sd1;

	// one queued sample, already classified by the front end
	typedef struct packed {
		logic                ovf;
		logic                last;
		logic                store;
		logic [SAMPLE_W-1:0] value;
	} orav_item_t;

	typedef struct packed {
		logic             start;
		logic [SUM_W-1:0] dividend;
		logic [CNT_W-1:0] divisor;
	} orav_div_req_t;

	typedef struct packed {
		logic             done;
		logic [SUM_W-1:0] quotient;
	} orav_div_rsp_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SUM,
		ST_MEAN_DIV,
		ST_DEV,
		ST_DEV_DIV,
		ST_SEL,
		ST_SEL_DIV,
		ST_EMIT
	} orav_state_t;

endpackage

// ----- rtl/orav_div.sv -----
// radix-2 restoring divider, one quotient bit per cycle
module orav_div (
	input  logic                   clk,
	input  logic                   arst_n,
	input  orav_pkg::orav_div_req_t req,
	output orav_pkg::orav_div_rsp_t rsp
);
	import orav_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [DSTEP_W-1:0] step_q;
	logic [CNT_W-1:0]   rem_q;
	logic [SUM_W-1:0]   quo_q;
	logic [CNT_W-1:0]   dvs_q;
	logic [CNT_W:0]     rem_sh;
	logic [CNT_W:0]     rem_diff;
	logic               fits;

	assign rem_sh   = {rem_q, quo_q[SUM_W-1]};
	assign fits     = rem_sh >= {1'b0, dvs_q};
	assign rem_diff = rem_sh - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DSTEP_W'(1);
				if (step_q == DSTEP_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= fits ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
			quo_q <= {quo_q[SUM_W-2:0], fits};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ----- rtl/orav_queue.sv -----
// short first-in first-out queue of classified samples
module orav_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  orav_pkg::orav_item_t push_item,
	output logic                full,
	input  logic                pop,
	output orav_pkg::orav_item_t pop_item,
	output logic                not_empty
);
	import orav_pkg::*;

	orav_item_t        slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   fill_q;
	logic              do_push;
	logic              do_pop;

	assign full      = fill_q == (QPTR_W + 1)'(QUEUE_DEPTH);
	assign not_empty = fill_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)  rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop) fill_q <= fill_q + (QPTR_W + 1)'(1);
			else if (do_pop && !do_push) fill_q <= fill_q - (QPTR_W + 1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) slot_q[wr_ptr_q] <= push_item;
	end

endmodule

// ----- rtl/orav_front.sv -----
// front end: takes samples, decides keep or drop and tracks window overflow
module orav_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [orav_pkg::SAMPLE_W-1:0] sample_value,
	input  logic                      sample_present,
	input  logic                      window_end,
	input  logic                      queue_full,
	output logic                      push,
	output orav_pkg::orav_item_t       item
);
	import orav_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic             accept;
	logic             room;
	logic             keep;
	logic             drop;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign room     = cnt_q != CNT_W'(WINDOW_DEPTH);
	assign keep     = sample_present && room;
	assign drop     = sample_present && !room;

	assign item.value = sample_value;
	assign item.store = keep;
	assign item.last  = window_end;
	assign item.ovf   = ovf_q || drop;
	// absent samples that do not close the window need no slot
	assign push       = accept && (keep || window_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (window_end) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				if (keep) cnt_q <= cnt_q + CNT_W'(1);
				if (drop) ovf_q <= 1'b1;
			end
		end
	end

endmodule

// ----- rtl/orav_back.sv -----
// back end: window store, three passes, shared divider and result register
module orav_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  orav_pkg::orav_item_t               item,
	input  logic                              item_valid,
	output logic                              pop,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [orav_pkg::SMOOTH_W-1:0] smoothed,
	output logic                              overflowed
);
	import orav_pkg::*;

	orav_state_t         state_q;
	orav_state_t         state_nx;
	logic [SAMPLE_W-1:0] win_mem_q [WINDOW_DEPTH];
	logic [CNT_W-1:0]    n_q;
	logic [CNT_W-1:0]    n_next;
	logic [CNT_W-1:0]    idx_q;
	logic                rvalid_s1;
	logic [SAMPLE_W-1:0] rdata_s1;
	logic [SUM_W-1:0]    acc_q;
	logic [CNT_W-1:0]    sel_n_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [SAMPLE_W-1:0] dev_q;
	logic                ovf_q;
	logic signed [SMOOTH_W-1:0] res_q;
	logic                out_valid_q;
	logic signed [SMOOTH_W-1:0] out_smoothed_q;
	logic                out_ovf_q;
	logic                in_pass;
	logic                issue;
	logic                pass_done;
	logic                emit_ok;
	logic [SAMPLE_W-1:0] gap;
	logic                sel_hit;
	orav_div_req_t       div_req;
	orav_div_rsp_t       div_rsp;

	orav_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign n_next  = n_q + CNT_W'(item.store);
	assign gap     = (rdata_s1 > mean_q) ? rdata_s1 - mean_q : mean_q - rdata_s1;
	assign sel_hit = (dev_q == '0) || (gap <= dev_q);

	// outputs of the sequencer
	always_comb begin
		in_pass   = (state_q == ST_SUM) || (state_q == ST_DEV) || (state_q == ST_SEL);
		pop       = (state_q == ST_LOAD) && item_valid;
		issue     = in_pass && (idx_q != n_q);
		pass_done = in_pass && (idx_q == n_q) && !rvalid_s1;
		emit_ok   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
		div_req.start    = pass_done && ((state_q != ST_SEL) || (sel_n_q != '0));
		div_req.dividend = acc_q;
		div_req.divisor  = (state_q == ST_SEL) ? sel_n_q : n_q;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_LOAD: begin
				if (pop && item.last) state_nx = (n_next == '0) ? ST_EMIT : ST_SUM;
			end
			ST_SUM: begin
				if (pass_done) state_nx = ST_MEAN_DIV;
			end
			ST_MEAN_DIV: begin
				if (div_rsp.done) state_nx = ST_DEV;
			end
			ST_DEV: begin
				if (pass_done) state_nx = ST_DEV_DIV;
			end
			ST_DEV_DIV: begin
				if (div_rsp.done) state_nx = ST_SEL;
			end
			ST_SEL: begin
				if (pass_done) state_nx = (sel_n_q == '0) ? ST_EMIT : ST_SEL_DIV;
			end
			ST_SEL_DIV: begin
				if (div_rsp.done) state_nx = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_ok) state_nx = ST_LOAD;
			end
			default: state_nx = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			n_q         <= '0;
			idx_q       <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_nx;
			rvalid_s1 <= issue;
			if (issue) idx_q <= idx_q + CNT_W'(1);
			if (pop) begin
				n_q <= n_next;
				if (item.last) idx_q <= '0;
			end
			if (((state_q == ST_MEAN_DIV) || (state_q == ST_DEV_DIV)) && div_rsp.done)
				idx_q <= '0;
			if (emit_ok) begin
				out_valid_q <= 1'b1;
				n_q         <= '0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.store) win_mem_q[n_q[ADDR_W-1:0]] <= item.value;
		if (issue) rdata_s1 <= win_mem_q[idx_q[ADDR_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			ovf_q <= item.ovf;
			acc_q <= '0;
			res_q <= SMOOTH_NONE;
		end
		if (rvalid_s1) begin
			unique case (state_q)
				ST_SUM: acc_q <= acc_q + SUM_W'(rdata_s1);
				ST_DEV: acc_q <= acc_q + SUM_W'(gap);
				ST_SEL: begin
					if (sel_hit) begin
						acc_q   <= acc_q + SUM_W'(rdata_s1);
						sel_n_q <= sel_n_q + CNT_W'(1);
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
		if (div_rsp.done) begin
			unique case (state_q)
				ST_MEAN_DIV: begin
					mean_q <= div_rsp.quotient[SAMPLE_W-1:0];
					acc_q  <= '0;
				end
				ST_DEV_DIV: begin
					dev_q   <= div_rsp.quotient[SAMPLE_W-1:0];
					acc_q   <= '0;
					sel_n_q <= '0;
				end
				ST_SEL_DIV: res_q <= {1'b0, div_rsp.quotient[SAMPLE_W-1:0]};
				default: res_q <= res_q;
			endcase
		end
		if (emit_ok) begin
			out_smoothed_q <= res_q;
			out_ovf_q      <= ovf_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign smoothed   = out_smoothed_q;
	assign overflowed = out_ovf_q;

endmodule

// ----- rtl/outlier_rejecting_average_core.sv -----
// outlier_rejecting_average_core: top level, outlier-rejecting window average
// throughput: one sample per cycle into the front end while the four-entry queue has room
// the back end drains one queued sample per cycle while loading a window
// after the window end the result follows three memory passes over the n stored samples,
// each followed by a division on the one shared divider; an empty window skips them all
// reset: asynchronous, clears counts, queue, sequencer and result valid; the store is not cleared
module outlier_rejecting_average_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// sample stream
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [orav_pkg::S_TDATA_W-1:0] s_axis_tdata,  // [9:0] sample_value, rest unused
	input  logic [0:0]                     s_axis_tuser,  // [0] sample_present
	input  logic                           s_axis_tlast,  // window_end
	// result stream
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [orav_pkg::M_TDATA_W-1:0] m_axis_tdata,  // [10:0] smoothed (signed), rest zero
	output logic [0:0]                     m_axis_tuser   // [0] overflowed
);
	import orav_pkg::*;

	logic                       q_full;
	logic                       q_push;
	logic                       q_pop;
	logic                       q_not_empty;
	orav_item_t                 push_item;
	orav_item_t                 head_item;
	logic signed [SMOOTH_W-1:0] smoothed;
	logic                       overflowed;

	// front end: classifies each sample as kept, dropped on overflow or skipped
	orav_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.sample_value   (s_axis_tdata[SAMPLE_W-1:0]),
		.sample_present (s_axis_tuser[0]),
		.window_end     (s_axis_tlast),
		.queue_full     (q_full),
		.push           (q_push),
		.item           (push_item)
	);

	// decoupling queue, lets the front keep taking samples while the back computes
	orav_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (head_item),
		.not_empty (q_not_empty)
	);

	// back end: mean, mean absolute deviation, then the mean of the samples within it
	orav_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (head_item),
		.item_valid (q_not_empty),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.smoothed   (smoothed),
		.overflowed (overflowed)
	);

	// pack the result transaction, padding bits held at zero
	assign m_axis_tdata = {{(M_TDATA_W - SMOOTH_W){1'b0}}, smoothed};
	assign m_axis_tuser = overflowed;

endmodule

// ----- rtl/orav_checker.sv -----
// port-level checker for the outlier-rejecting average, bound to the top level
`include "assert_macros.svh"

module orav_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [orav_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic [0:0]                     s_axis_tuser,
	input logic                           s_axis_tlast,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [orav_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [0:0]                     m_axis_tuser
);
	import orav_pkg::*;

	// a stalled result stays offered and unchanged
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
	`ASSERT_NEXT(a_out_stable, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")
	// an average is a sample value or the empty-window marker
	`ASSERT_SAME(a_range, clk, arst_n, m_axis_tvalid, !m_axis_tdata[SMOOTH_W-1] || (m_axis_tdata[SMOOTH_W-1:0] == SMOOTH_NONE), "average out of range")
	// an empty window can never have overflowed
	`ASSERT_SAME(a_empty_no_ovf, clk, arst_n, m_axis_tvalid && (m_axis_tdata[SMOOTH_W-1:0] == SMOOTH_NONE), !m_axis_tuser[0], "overflow flagged on empty window")
	`ASSERT_SAME(a_pad_zero, clk, arst_n, m_axis_tvalid, m_axis_tdata[M_TDATA_W-1:SMOOTH_W] == '0, "padding bits set")

endmodule

bind outlier_rejecting_average_core orav_checker u_orav_checker (.*);

// ----- dv/tb_outlier_rejecting_average_core.sv -----
`timescale 1ns / 100ps
// testbench of outlier_rejecting_average_core: sample windows checked against a predicted average
module tb_outlier_rejecting_average_core;
	import orav_pkg::*;

	localparam int CLK_PERIOD   = 12;
	localparam int IDLE_PCT     = 28;
	localparam int ITEM_TARGET  = 1050;
	localparam int HOLD_AFTER   = 12;   // results seen before the long sink hold-off
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 5000; // cycles with no transaction on either side
	localparam int DRAIN_CYCLES = 200;  // extra wait after the last expected result, to catch stray results

	typedef struct {
		logic [SMOOTH_W-1:0] smoothed;
		logic                overflowed;
	} window_average_t;

	class smoothed_result_tracker;
		logic [SAMPLE_W-1:0] window_q[$];
		logic                dropped;
		window_average_t     pending_averages[$];
		int                  mismatches;

		function new();
			dropped    = 1'b0;
			mismatches = 0;
		endfunction

		function int unsigned abs_gap(int unsigned a, int unsigned b);
			return (a > b) ? a - b : b - a;
		endfunction

		// mean, mean deviation, then mean of the samples within the deviation
		function logic [SMOOTH_W-1:0] outlier_rejected_mean();
			int unsigned n, total, mean, dsum, dev, sel_total, sel_n;
			n = window_q.size();
			if (n == 0)
				return SMOOTH_NONE;
			total = 0;
			foreach (window_q[i])
				total += window_q[i];
			mean = total / n;
			dsum = 0;
			foreach (window_q[i])
				dsum += abs_gap(window_q[i], mean);
			dev = dsum / n;
			sel_total = 0;
			sel_n     = 0;
			foreach (window_q[i]) begin
				if (dev == 0 || abs_gap(window_q[i], mean) <= dev) begin
					sel_total += window_q[i];
					sel_n++;
				end
			end
			if (sel_n == 0)
				return SMOOTH_NONE;
			return SMOOTH_W'(sel_total / sel_n);
		endfunction

		function void note_sample(logic [SAMPLE_W-1:0] value, logic present, logic last);
			window_average_t avg;
			if (present) begin
				if (window_q.size() < WINDOW_DEPTH)
					window_q.push_back(value);
				else
					dropped = 1'b1;
			end
			if (last) begin
				avg.smoothed   = outlier_rejected_mean();
				avg.overflowed = dropped;
				pending_averages.push_back(avg);
				window_q.delete();
				dropped = 1'b0;
			end
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(logic [M_TDATA_W-1:0] data, logic [0:0] user);
			window_average_t want;
			if (pending_averages.size() == 0) begin
				report($sformatf("unexpected result smoothed=%0d overflowed=%0b",
					$signed(data[SMOOTH_W-1:0]), user[0]));
				return;
			end
			want = pending_averages.pop_front();
			if (data[SMOOTH_W-1:0] !== want.smoothed)
				report($sformatf("smoothed %0d, expected %0d",
					$signed(data[SMOOTH_W-1:0]), $signed(want.smoothed)));
			if (user[0] !== want.overflowed)
				report($sformatf("overflowed %0b, expected %0b", user[0], want.overflowed));
			if (data[M_TDATA_W-1:SMOOTH_W] !== '0)
				report($sformatf("tdata padding %0h, expected zero",
					data[M_TDATA_W-1:SMOOTH_W]));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [0:0]           s_axis_tuser;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [0:0]           m_axis_tuser;

	smoothed_result_tracker board = new();
	int                     items_sent = 0;

	outlier_rejecting_average_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	// one sample transaction; the unused tdata bits carry random junk
	task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic present,
	                           input logic last);
		while (!(items_sent >= 300 && items_sent < 500) && $urandom_range(99) < IDLE_PCT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {(S_TDATA_W - SAMPLE_W)'($urandom), value};
		s_axis_tuser  <= present;
		s_axis_tlast  <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		board.note_sample(value, present, last);
		items_sent++;
	endtask

	// a window of samples spread around a centre, with the odd wild sample
	task automatic send_window(input int len, input int absent_pct, input int spread);
		int centre, v;
		centre = $urandom_range(1023);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(99) < 8)
				v = $urandom_range(1023);
			else
				v = centre + int'($urandom_range(2 * spread)) - spread;
			if (v < 0)
				v = 0;
			if (v > 1023)
				v = 1023;
			send_sample(SAMPLE_W'(v), $urandom_range(99) >= absent_pct, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int kind, spread;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		s_axis_tlast  <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single sample at full scale
		send_sample(10'd1023, 1'b1, 1'b1);
		// no sample present at all
		send_sample(10'd1023, 1'b0, 1'b1);
		// absent sample on the closing transaction
		send_sample(10'd0,    1'b1, 1'b0);
		send_sample(10'd1023, 1'b1, 1'b0);
		send_sample(10'd512,  1'b0, 1'b1);
		// identical samples, deviation zero
		repeat (3) send_sample(10'd7, 1'b1, 1'b0);
		send_sample(10'd7, 1'b1, 1'b1);
		// one wild sample among a tight cluster, gap in the middle
		send_sample(10'd100, 1'b1, 1'b0);
		send_sample(10'd102, 1'b1, 1'b0);
		send_sample(10'd98,  1'b1, 1'b0);
		send_sample(10'd900, 1'b1, 1'b0);
		send_sample(10'd0,   1'b0, 1'b0);
		send_sample(10'd101, 1'b1, 1'b1);
		// all zero
		send_sample(10'd0, 1'b1, 1'b0);
		send_sample(10'd0, 1'b1, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			kind = $urandom_range(99);
			case ($urandom_range(3))
				0: spread = 0;
				1: spread = 3;
				2: spread = 40;
				default: spread = 500;
			endcase
			if (kind < 12)
				send_window($urandom_range(WINDOW_DEPTH + 1, WINDOW_DEPTH + 8), 8, spread);
			else if (kind < 22)
				send_window($urandom_range(1, 3), 50, spread);
			else
				send_window($urandom_range(2, WINDOW_DEPTH), 10, spread);
		end
		s_axis_tvalid <= 1'b0;

		while (board.pending_averages.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.pending_averages.size() == 0)
			$display("outlier_rejecting_average_core test passed");
		else
			$display("outlier_rejecting_average_core test failed");
		$finish;
	end

	// result sink: random back-pressure, a stretch of steady readiness, and one long hold-off
	initial begin : result_sink
		int results_seen, hold_left;
		results_seen = 0;
		hold_left    = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				board.check_result(m_axis_tdata, m_axis_tuser);
				results_seen++;
				if (results_seen == HOLD_AFTER)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (results_seen >= 30 && results_seen < 60) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("outlier_rejecting_average_core test failed");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/orav_pkg.sv
rtl/orav_div.sv
rtl/orav_queue.sv
rtl/orav_front.sv
rtl/orav_back.sv
rtl/outlier_rejecting_average_core.sv
rtl/orav_checker.sv
dv/tb_outlier_rejecting_average_core.sv
